/* design/lcbb_pkg.sv */
// ============================================================================
// LRU cache with byte budget: shared package
// Request codes, sweep kinds and the command and status bundles that pass
// between the controller and the datapath.
// ============================================================================
package lcbb_pkg;

    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_PROBE  = 2'd1;
    localparam logic [1:0] REQ_INSERT = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    localparam int KEY_W    = 64;
    localparam int HANDLE_W = 32;
    localparam int BYTES_W  = 32;
    localparam int TOTAL_W  = 39;
    localparam int BUDGET_W = 48;
    localparam int CNT_W    = 7;
    localparam int S_DATA_W = 128;
    localparam int M_DATA_W = 88;
    localparam logic [BUDGET_W-1:0] BUDGET_RESET = 48'd268435456;

    typedef enum logic [2:0] {
        SW_FIND  = 3'b001,
        SW_RANK  = 3'b010,
        SW_EVICT = 3'b100
    } sweep_op_t;

    typedef struct packed {
        logic accept;
        logic start_find;
        logic start_rank;
        logic rank_all;
        logic start_evict;
        logic do_replace;
        logic do_insert;
        logic rank_zero;
        logic do_clear;
        logic load_out;
    } lcbb_cmd_t;

    typedef struct packed {
        logic       busy;
        logic [1:0] req_type;
        logic       hit;
        logic       handle_nz;
        logic       full;
        logic       over;
        logic       out_free;
    } lcbb_sts_t;

endpackage

/* design/lcbb_ctrl.sv */
// ============================================================================
// LRU cache with byte budget: controller
// Sequences the find, recency and eviction sweeps for one request at a time.
// ============================================================================
module lcbb_ctrl
    import lcbb_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  lcbb_sts_t sts,
    output lcbb_cmd_t cmd
);

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_START   = 9'b000000010,
        ST_FIND    = 9'b000000100,
        ST_TOUCH   = 9'b000001000,
        ST_EVFULL  = 9'b000010000,
        ST_INSRANK = 9'b000100000,
        ST_CHECK   = 9'b001000000,
        ST_EVICT   = 9'b010000000,
        ST_DONE    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                if (sts.req_type == REQ_CLEAR) begin
                    cmd.do_clear = 1'b1;
                    state_next   = ST_DONE;
                end else begin
                    cmd.start_find = 1'b1;
                    state_next     = ST_FIND;
                end
            end
            ST_FIND: begin
                if (!sts.busy) begin
                    if (sts.req_type == REQ_LOOKUP && sts.hit) begin
                        cmd.start_rank = 1'b1;
                        state_next     = ST_TOUCH;
                    end else if (sts.req_type == REQ_INSERT && sts.handle_nz) begin
                        if (sts.hit) begin
                            cmd.do_replace = 1'b1;
                            cmd.start_rank = 1'b1;
                            state_next     = ST_TOUCH;
                        end else if (sts.full) begin
                            cmd.start_evict = 1'b1;
                            state_next      = ST_EVFULL;
                        end else begin
                            cmd.start_rank = 1'b1;
                            cmd.rank_all   = 1'b1;
                            state_next     = ST_INSRANK;
                        end
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_TOUCH: begin
                if (!sts.busy) begin
                    cmd.rank_zero = 1'b1;
                    state_next    = (sts.req_type == REQ_INSERT) ? ST_CHECK : ST_DONE;
                end
            end
            ST_EVFULL: begin
                if (!sts.busy) begin
                    cmd.start_rank = 1'b1;
                    cmd.rank_all   = 1'b1;
                    state_next     = ST_INSRANK;
                end
            end
            ST_INSRANK: begin
                if (!sts.busy) begin
                    cmd.do_insert = 1'b1;
                    cmd.rank_zero = 1'b1;
                    state_next    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.over) begin
                    cmd.start_evict = 1'b1;
                    state_next      = ST_EVICT;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_EVICT: begin
                if (!sts.busy) begin
                    state_next = ST_CHECK;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* design/lcbb_dpath.sv */
// ============================================================================
// LRU cache with byte budget: datapath
// Entry memories, valid bits, byte total, sweep engine and result register.
// ============================================================================
module lcbb_dpath
    import lcbb_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [1:0]            s_tuser,
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic                  cfg_valid,
    input  logic [BUDGET_W-1:0]   cfg_data,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [M_DATA_W-1:0]   m_tdata,
    input  lcbb_cmd_t             cmd,
    output lcbb_sts_t             sts
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    logic [KEY_W-1:0]    tag_mem    [ENTRIES];
    logic [HANDLE_W-1:0] handle_mem [ENTRIES];
    logic [BYTES_W-1:0]  size_mem   [ENTRIES];
    logic [IW-1:0]       rank_mem   [ENTRIES];

    logic [ENTRIES-1:0]  valid_reg;
    logic [TOTAL_W-1:0]  total_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       evicted_reg;
    logic [BUDGET_W-1:0] budget_reg;

    logic [1:0]          req_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [BYTES_W-1:0]  bytes_reg;

    logic                active_reg, p_vld_reg;
    logic [IW-1:0]       idx_reg, p_idx_reg;
    sweep_op_t           op_reg;
    logic [CW-1:0]       thresh_reg;
    logic [IW-1:0]       target_reg;

    logic [KEY_W-1:0]    tag_rd_reg;
    logic [HANDLE_W-1:0] handle_rd_reg;
    logic [BYTES_W-1:0]  size_rd_reg;
    logic [IW-1:0]       rank_rd_reg;

    logic                hit_reg, free_found_reg;
    logic [IW-1:0]       hit_slot_reg, free_slot_reg, hit_rank_reg;
    logic [HANDLE_W-1:0] hit_handle_reg;
    logic [BYTES_W-1:0]  hit_size_reg;

    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    logic                cur_valid, find_match, free_match, rank_inc, ev_match;
    logic                start_any;
    logic [IW-1:0]       wslot;
    logic [HANDLE_W-1:0] found_handle;

    assign start_any  = cmd.start_find | cmd.start_rank | cmd.start_evict;
    assign cur_valid  = valid_reg[p_idx_reg];
    assign find_match = p_vld_reg && op_reg == SW_FIND && cur_valid && tag_rd_reg == key_reg;
    assign free_match = p_vld_reg && op_reg == SW_FIND && !cur_valid && !free_found_reg;
    assign rank_inc   = p_vld_reg && op_reg == SW_RANK && cur_valid
                        && CW'(rank_rd_reg) < thresh_reg;
    assign ev_match   = p_vld_reg && op_reg == SW_EVICT && cur_valid
                        && rank_rd_reg == target_reg;
    assign wslot      = hit_reg ? hit_slot_reg : free_slot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= 1'b0;
            p_vld_reg    <= 1'b0;
            valid_reg    <= '0;
            total_reg    <= '0;
            count_reg    <= '0;
            budget_reg   <= BUDGET_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            p_vld_reg <= active_reg;
            if (start_any) begin
                active_reg <= 1'b1;
            end else if (active_reg && idx_reg == IW'(ENTRIES - 1)) begin
                active_reg <= 1'b0;
            end
            if (cfg_valid) begin
                budget_reg <= cfg_data;
            end
            if (cmd.do_clear) begin
                valid_reg <= '0;
                total_reg <= '0;
                count_reg <= '0;
            end else if (ev_match) begin
                valid_reg[p_idx_reg] <= 1'b0;
                total_reg <= total_reg - TOTAL_W'(size_rd_reg);
                count_reg <= count_reg - CW'(1);
            end else if (cmd.do_insert) begin
                valid_reg[free_slot_reg] <= 1'b1;
                total_reg <= total_reg + TOTAL_W'(bytes_reg);
                count_reg <= count_reg + CW'(1);
            end else if (cmd.do_replace) begin
                total_reg <= total_reg - TOTAL_W'(hit_size_reg) + TOTAL_W'(bytes_reg);
            end
            if (cmd.load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start_any) begin
            idx_reg <= '0;
        end else if (active_reg) begin
            idx_reg <= idx_reg + IW'(1);
        end
        p_idx_reg     <= idx_reg;
        tag_rd_reg    <= tag_mem[idx_reg];
        handle_rd_reg <= handle_mem[idx_reg];
        size_rd_reg   <= size_mem[idx_reg];
        rank_rd_reg   <= rank_mem[idx_reg];

        if (cmd.accept) begin
            req_reg     <= s_tuser;
            key_reg     <= s_tdata[63:0];
            handle_reg  <= s_tdata[95:64];
            bytes_reg   <= s_tdata[127:96];
            hit_reg     <= 1'b0;
            evicted_reg <= '0;
        end else if (ev_match) begin
            evicted_reg <= evicted_reg + CW'(1);
        end
        if (cmd.start_find) begin
            op_reg         <= SW_FIND;
            free_found_reg <= 1'b0;
        end else if (cmd.start_rank) begin
            op_reg     <= SW_RANK;
            thresh_reg <= cmd.rank_all ? count_reg : CW'(hit_rank_reg);
        end else if (cmd.start_evict) begin
            op_reg     <= SW_EVICT;
            target_reg <= IW'(count_reg - CW'(1));
        end
        if (find_match) begin
            hit_reg        <= 1'b1;
            hit_slot_reg   <= p_idx_reg;
            hit_handle_reg <= handle_rd_reg;
            hit_size_reg   <= size_rd_reg;
            hit_rank_reg   <= rank_rd_reg;
        end
        if (free_match) begin
            free_found_reg <= 1'b1;
            free_slot_reg  <= p_idx_reg;
        end else if (ev_match) begin
            free_slot_reg <= p_idx_reg;
        end
        if (cmd.load_out) begin
            m_tdata_reg <= {2'b00, CNT_W'(evicted_reg), CNT_W'(count_reg),
                            total_reg, found_handle, hit_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (rank_inc) begin
            rank_mem[p_idx_reg] <= rank_rd_reg + IW'(1);
        end else if (cmd.rank_zero) begin
            rank_mem[wslot] <= '0;
        end
        if (cmd.do_insert) begin
            tag_mem[free_slot_reg] <= key_reg;
        end
        if (cmd.do_insert || cmd.do_replace) begin
            handle_mem[wslot] <= handle_reg;
            size_mem[wslot]   <= bytes_reg;
        end
    end

    assign found_handle  = (req_reg == REQ_LOOKUP && hit_reg) ? hit_handle_reg : '0;

    assign sts.busy      = active_reg | p_vld_reg;
    assign sts.req_type  = req_reg;
    assign sts.hit       = hit_reg;
    assign sts.handle_nz = (handle_reg != '0);
    assign sts.full      = (count_reg == CW'(ENTRIES));
    assign sts.over      = (BUDGET_W'(total_reg) > budget_reg) && (count_reg > CW'(1));
    assign sts.out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* design/lru_cache_byte_budget_core.sv */
// ============================================================================
// LRU cache with byte budget: top level
// Handle cache keyed by 64-bit tags with least-recent eviction under a budget.
//
//   Channel  Direction  Contents
//   s_       in         request: tuser kind, tdata key, handle, bytes
//   m_       out        result: hit, handle, bytes used, entries, evictions
//   cfg_     in         byte budget write
//
// Every request except clear runs a find sweep over all ENTRIES slots
// through the single read port of the entry memories. A lookup hit or an
// insert with a nonzero handle adds one recency sweep of the same length,
// and each eviction adds one more sweep. Reset empties the table at once.
// A result waiting on m_tready holds the next request only at its final
// step.
// ============================================================================
module lru_cache_byte_budget_core
    import lcbb_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // key_tag, item_handle, item_bytes
    input  logic [1:0]          s_tuser,   // req_type
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // hit, found_handle, used_bytes,
                                           // entry_count, evicted_count
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [BUDGET_W-1:0] cfg_data
);

    lcbb_cmd_t cmd;
    lcbb_sts_t sts;

    assign cfg_ready = 1'b1;

    lcbb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lcbb_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

/* design/lcbb_checker.sv */
// ============================================================================
// LRU cache with byte budget: port checker
// Checks result and handshake behavior seen at the top-level ports.
// ============================================================================
module lcbb_checker
    import lcbb_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_miss_handle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[32:1] == '0)
        else $error("handle returned on a miss");

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ENTRIES < 128 |-> m_tdata[78:72] <= ENTRIES)
        else $error("entry count above capacity");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind lru_cache_byte_budget_core lcbb_checker #(
    .ENTRIES (ENTRIES)
) u_lcbb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* dv/lru_cache_byte_budget_core_tb.sv */
// ============================================================================
// LRU cache with byte budget: testbench
// Drives lookups, probes, inserts and clears with random handshake gaps and
// compares every result transfer against a cycle-free model of the cache,
// with budget changes between phases.
// ============================================================================
module lru_cache_byte_budget_core_tb;
    import lcbb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = 64;
    localparam int LIMIT_CYCLES = 2000000;

    typedef struct packed {
        logic [CNT_W-1:0]    evicted_count;
        logic [CNT_W-1:0]    entry_count;
        logic [TOTAL_W-1:0]  used_bytes;
        logic [HANDLE_W-1:0] found_handle;
        logic                hit;
    } result_t;

    typedef struct {
        logic [1:0]          kind;
        logic [KEY_W-1:0]    tag;
        logic [HANDLE_W-1:0] handle;
        logic [BYTES_W-1:0]  bytes;
        logic                has_exp;
        result_t             exp;
    } req_row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [1:0]          s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [BUDGET_W-1:0] cfg_data = '0;

    lru_cache_byte_budget_core u_dut (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Model state of the cache.
    logic [KEY_W-1:0]    mdl_tag [NSLOT];
    logic [HANDLE_W-1:0] mdl_handle [NSLOT];
    logic [BYTES_W-1:0]  mdl_size [NSLOT];
    logic                mdl_valid [NSLOT];
    int unsigned         mdl_rank [NSLOT];
    logic [63:0]         mdl_total;
    int unsigned         mdl_count;
    logic [BUDGET_W-1:0] mdl_budget;

    result_t             pending_results[$];
    int                  errors = 0;
    int                  n_results = 0;
    int                  n_hits = 0;
    int                  n_evicts = 0;
    longint              cycles = 0;
    bit                  hold_off = 1'b0;
    bit                  quiet_rx = 1'b0;

    function automatic int find_slot(logic [KEY_W-1:0] tag);
        for (int i = 0; i < NSLOT; i++)
            if (mdl_valid[i] && mdl_tag[i] == tag) return i;
        return -1;
    endfunction

    function automatic void promote(int slot);
        int unsigned r;
        r = mdl_rank[slot];
        for (int i = 0; i < NSLOT; i++)
            if (mdl_valid[i] && mdl_rank[i] < r) mdl_rank[i]++;
        mdl_rank[slot] = 0;
    endfunction

    function automatic void drop_oldest();
        if (mdl_count == 0) return;
        for (int i = 0; i < NSLOT; i++)
            if (mdl_valid[i] && mdl_rank[i] == mdl_count - 1) begin
                mdl_valid[i] = 1'b0;
                mdl_total -= mdl_size[i];
                mdl_count--;
                return;
            end
    endfunction

    function automatic result_t cache_access(logic [1:0] kind, logic [KEY_W-1:0] tag,
                                             logic [HANDLE_W-1:0] handle,
                                             logic [BYTES_W-1:0] bytes);
        result_t r;
        int slot;
        int unsigned ev;
        r = '0;
        ev = 0;
        slot = -1;
        if (kind != REQ_CLEAR) begin
            slot = find_slot(tag);
            r.hit = (slot >= 0);
        end
        case (kind)
            REQ_LOOKUP: begin
                if (slot >= 0) begin
                    r.found_handle = mdl_handle[slot];
                    promote(slot);
                end
            end
            REQ_PROBE: begin
            end
            REQ_INSERT: begin
                if (handle != 0) begin
                    if (slot >= 0) begin
                        mdl_total = mdl_total - mdl_size[slot] + bytes;
                        mdl_handle[slot] = handle;
                        mdl_size[slot] = bytes;
                        promote(slot);
                    end else begin
                        if (mdl_count >= NSLOT) begin
                            drop_oldest();
                            ev++;
                        end
                        for (int i = 0; i < NSLOT; i++)
                            if (!mdl_valid[i]) begin
                                slot = i;
                                break;
                            end
                        for (int i = 0; i < NSLOT; i++)
                            if (mdl_valid[i]) mdl_rank[i]++;
                        mdl_valid[slot] = 1'b1;
                        mdl_tag[slot] = tag;
                        mdl_handle[slot] = handle;
                        mdl_size[slot] = bytes;
                        mdl_rank[slot] = 0;
                        mdl_total += bytes;
                        mdl_count++;
                    end
                    while (mdl_total > mdl_budget && mdl_count > 1) begin
                        drop_oldest();
                        ev++;
                    end
                end
            end
            REQ_CLEAR: begin
                for (int i = 0; i < NSLOT; i++) mdl_valid[i] = 1'b0;
                mdl_total = 0;
                mdl_count = 0;
            end
            default: begin
            end
        endcase
        r.used_bytes = mdl_total[TOTAL_W-1:0];
        r.entry_count = mdl_count[CNT_W-1:0];
        r.evicted_count = ev[CNT_W-1:0];
        return r;
    endfunction

    task automatic send_request(req_row_t row);
        result_t r;
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
        repeat (gap) @(posedge aclk);
        s_tvalid <= 1'b1;
        s_tuser <= row.kind;
        s_tdata <= {row.bytes, row.handle, row.tag};
        do @(posedge aclk); while (!s_tready);
        s_tvalid <= 1'b0;
        r = cache_access(row.kind, row.tag, row.handle, row.bytes);
        if (row.has_exp && r != row.exp) begin
            errors++;
            $error("directed row: model result %h differs from the typed-in value %h",
                   r, row.exp);
        end
        pending_results.push_back(r);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_budget(logic [BUDGET_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        mdl_budget = value;
    endtask

    // Receiver with random stalls.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (hold_off)
                m_tready <= 1'b0;
            else if (quiet_rx)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 19) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge aclk) begin
        result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[85:0]);
            if (pending_results.size() == 0) begin
                errors++;
                $error("result transfer with no request outstanding: %h", m_tdata);
            end else begin
                want = pending_results.pop_front();
                n_results++;
                if (got.hit) n_hits++;
                n_evicts += got.evicted_count;
                if (got.hit != want.hit)
                    $error("hit: expected %0d, got %0d", want.hit, got.hit);
                if (got.found_handle != want.found_handle)
                    $error("found_handle: expected %h, got %h",
                           want.found_handle, got.found_handle);
                if (got.used_bytes != want.used_bytes)
                    $error("used_bytes: expected %0d, got %0d",
                           want.used_bytes, got.used_bytes);
                if (got.entry_count != want.entry_count)
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, got.entry_count);
                if (got.evicted_count != want.evicted_count)
                    $error("evicted_count: expected %0d, got %0d",
                           want.evicted_count, got.evicted_count);
                if (got != want) errors++;
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic req_row_t mk(logic [1:0] kind, logic [KEY_W-1:0] tag,
                                    logic [HANDLE_W-1:0] handle,
                                    logic [BYTES_W-1:0] bytes, logic has_exp,
                                    result_t exp);
        req_row_t row;
        row.kind = kind;
        row.tag = tag;
        row.handle = handle;
        row.bytes = bytes;
        row.has_exp = has_exp;
        row.exp = exp;
        return row;
    endfunction

    function automatic result_t res(logic hit, logic [HANDLE_W-1:0] h, logic [TOTAL_W-1:0] u,
                                    logic [CNT_W-1:0] c, logic [CNT_W-1:0] e);
        result_t r;
        r.hit = hit;
        r.found_handle = h;
        r.used_bytes = u;
        r.entry_count = c;
        r.evicted_count = e;
        return r;
    endfunction

    function automatic req_row_t rand_row(int unsigned pool);
        req_row_t row;
        int unsigned p;
        row.has_exp = 1'b0;
        row.exp = '0;
        p = $urandom_range(0, 99);
        row.kind = (p < 30) ? REQ_LOOKUP : (p < 45) ? REQ_PROBE : (p < 98) ? REQ_INSERT
                                                                          : REQ_CLEAR;
        if ($urandom_range(0, 9) == 0)
            row.tag = {$urandom, $urandom};
        else
            row.tag = {32'hA5A5_0000 ^ {2'b00, 2'($urandom_range(0, 3)), 28'd0}, 32'd0} +
                      64'($urandom_range(0, pool - 1));
        row.handle = ($urandom_range(0, 19) == 0) ? '0 : $urandom;
        case ($urandom_range(0, 5))
            0:       row.bytes = $urandom;
            1:       row.bytes = 32'hFFFF_FFFF;
            default: row.bytes = $urandom_range(0, 4000);
        endcase
        return row;
    endfunction

    localparam logic [KEY_W-1:0] KMAX = {KEY_W{1'b1}};
    localparam logic [HANDLE_W-1:0] HMAX = {HANDLE_W{1'b1}};

    initial begin
        req_row_t directed[$];
        req_row_t row;
        logic [BUDGET_W-1:0] budgets[5];

        for (int i = 0; i < NSLOT; i++) mdl_valid[i] = 1'b0;
        mdl_total = 0;
        mdl_count = 0;
        mdl_budget = BUDGET_RESET;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed.push_back(mk(REQ_LOOKUP, 64'd5, 32'd0, 32'd0, 1, res(0, 0, 0, 0, 0)));
        directed.push_back(mk(REQ_PROBE, KMAX, 32'd0, 32'd0, 1, res(0, 0, 0, 0, 0)));
        directed.push_back(mk(REQ_INSERT, KMAX, HMAX, 32'd100, 1, res(0, 0, 100, 1, 0)));
        directed.push_back(mk(REQ_LOOKUP, KMAX, 32'd0, 32'd0, 1, res(1, HMAX, 100, 1, 0)));
        directed.push_back(mk(REQ_PROBE, KMAX, 32'd0, 32'd0, 1, res(1, 0, 100, 1, 0)));
        directed.push_back(mk(REQ_INSERT, KMAX, 32'd0, 32'd9, 1, res(1, 0, 100, 1, 0)));
        directed.push_back(mk(REQ_INSERT, 64'd0, 32'd1, 32'd0, 1, res(0, 0, 100, 2, 0)));
        directed.push_back(mk(REQ_INSERT, 64'd0, 32'd2, 32'd50, 0, '0));
        directed.push_back(mk(REQ_INSERT, 64'd7, 32'h8000_0000, 32'h0FFF_FFFF, 0, '0));
        directed.push_back(mk(REQ_INSERT, 64'd8, 32'd3, 32'hFFFF_FFFF, 0, '0));
        directed.push_back(mk(REQ_LOOKUP, 64'd8, 32'd0, 32'd0, 0, '0));
        directed.push_back(mk(REQ_CLEAR, KMAX, HMAX, 32'hFFFF_FFFF, 1, res(0, 0, 0, 0, 0)));
        directed.push_back(mk(REQ_PROBE, 64'd8, 32'd0, 32'd0, 1, res(0, 0, 0, 0, 0)));
        foreach (directed[i]) send_request(directed[i]);
        wait_drained();

        // Fill past ENTRIES so that a full table forces an eviction.
        write_budget({BUDGET_W{1'b1}});
        for (int i = 0; i < NSLOT + 4; i++)
            send_request(mk(REQ_INSERT, 64'h100 + i, 32'h10 + i, 32'd1 << (i % 32), 0, '0));
        send_request(mk(REQ_LOOKUP, 64'h100 + 10, 0, 0, 0, '0));
        wait_drained();

        // Zero budget keeps only the newest entry.
        write_budget('0);
        send_request(mk(REQ_INSERT, 64'h999, 32'd77, 32'd1, 0, '0));
        send_request(mk(REQ_INSERT, 64'h998, 32'd78, 32'd0, 0, '0));
        wait_drained();

        budgets[0] = BUDGET_RESET;
        budgets[1] = 48'd20000;
        budgets[2] = {BUDGET_W{1'b1}};
        budgets[3] = 48'd0;
        budgets[4] = 48'h0000_FFFF_FFFF;
        for (int ph = 0; ph < 5; ph++) begin
            write_budget(ph == 4 ? BUDGET_W'({$urandom, $urandom}) : budgets[ph]);
            for (int n = 0; n < 120; n++) begin
                if (ph == 1 && n == 40) begin
                    hold_off = 1'b1;
                    fork
                        begin
                            repeat (600) @(posedge aclk);
                            hold_off = 1'b0;
                        end
                    join_none
                end
                if (n == 90) begin
                    wait_drained();
                    quiet_rx = (ph == 2);
                end
                row = rand_row(ph == 2 ? 90 : 24);
                send_request(row);
            end
            wait_drained();
            quiet_rx = 1'b0;
        end

        $display("Checked %0d results: %0d hits, %0d evictions over five budget settings.",
                 n_results, n_hits, n_evicts);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* filelist.f */
design/lcbb_pkg.sv
design/lcbb_ctrl.sv
design/lcbb_dpath.sv
design/lru_cache_byte_budget_core.sv
design/lcbb_checker.sv
dv/lru_cache_byte_budget_core_tb.sv
